/* sv/hpn_pkg.sv */
// hpn_pkg: shared widths, sizes and request codes for the histogram peak
// normalize core. No dependencies.

package hpn_pkg;

    localparam int COUNT_BITS     = 20;
    localparam int BIN_BITS       = 8;
    localparam int NUM_BINS       = 1 << BIN_BITS;
    localparam int HEIGHT_BITS    = 9;
    localparam int OUT_COUNT_BITS = 20;
    localparam int KIND_BITS      = 2;

    // Fraction bits of count*256/peak, one per divider step.
    localparam int DIV_STEPS      = HEIGHT_BITS - 1;
    localparam int STEP_BITS      = $clog2(DIV_STEPS + 1);

    typedef enum logic [KIND_BITS-1:0] {
        KIND_PIXEL = 2'd0,
        KIND_READ  = 2'd1,
        KIND_CLEAR = 2'd2
    } kind_t;

endpackage

/* sv/histogram_peak_normalize_core.sv */
// histogram_peak_normalize_core: 256-bin grey-level histogram with a running
// peak and a bit-serial height divider. Depends on hpn_pkg.
//
//  channel  | signals                        | direction | moves
//  ---------+--------------------------------+-----------+----------------------
//  in       | in_valid in_ready kind pix bin | sink      | pixel/read/clear req
//  out      | out_valid out_ready bin_count  | source    | read result
//           | bar_height empty_flag          |           |
//
// Pixels stream at one request per cycle while no read is held in the request
// stage: the bin memory is read at accept and written back in the next cycle,
// with the last write forwarded. A read does its memory read in the request
// stage, then launches 8 steps of the shared restoring divider. A read of an
// empty histogram skips the divider and shows its result from the request stage.
// A clear needs no sweep: the per-bin valid flops drop together.
// Reset leaves the histogram empty. A held result or a busy divider stalls
// the next read, and every request behind it, until the result is taken.

module histogram_peak_normalize_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [hpn_pkg::KIND_BITS-1:0]      kind,
    input  logic [hpn_pkg::BIN_BITS-1:0]       pixel,
    input  logic [hpn_pkg::BIN_BITS-1:0]       bin,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [hpn_pkg::OUT_COUNT_BITS-1:0] bin_count,
    output logic [hpn_pkg::HEIGHT_BITS-1:0]    bar_height,
    output logic                              empty_flag
);

    localparam int CB = hpn_pkg::COUNT_BITS;
    localparam int BB = hpn_pkg::BIN_BITS;
    localparam int HB = hpn_pkg::HEIGHT_BITS;
    localparam int SB = hpn_pkg::STEP_BITS;
    localparam int OB = hpn_pkg::OUT_COUNT_BITS;

    // Bin memory with a registered read port
    logic [CB-1:0]                   bin_mem [hpn_pkg::NUM_BINS];
    logic [CB-1:0]                   rdata_reg;
    logic                            rd_vld_reg;
    logic [hpn_pkg::NUM_BINS-1:0]    bin_vld_reg;

    // Request stage holding the item whose memory read is in flight
    logic                            s1_valid_reg;
    hpn_pkg::kind_t                  s1_kind_reg;
    logic [BB-1:0]                   s1_addr_reg;

    // Last write-back and clear, for forwarding
    logic                            wr_valid_reg;
    logic [BB-1:0]                   wr_addr_reg;
    logic [CB-1:0]                   wr_data_reg;
    logic                            clr_last_reg;

    logic [CB-1:0]                   peak_reg;

    // Divider and result registers
    logic [SB-1:0]                   div_cnt_reg;
    logic [CB-1:0]                   div_rem_reg;
    logic [CB-1:0]                   div_peak_reg;
    logic [HB-1:0]                   quo_reg;
    logic [OB-1:0]                   cnt_out_reg;
    logic                            empty_reg;
    logic                            out_valid_reg;

    logic                            in_acc;
    logic [BB-1:0]                   rd_addr;
    logic [CB-1:0]                   cur_count;
    logic                            inc_ok;
    logic [CB-1:0]                   inc_count;
    logic                            div_busy;
    logic                            res_free;
    logic                            s1_go;
    logic                            s1_pixel;
    logic                            s1_read;
    logic                            s1_clear;
    logic                            mem_we;
    logic                            at_peak;
    logic [CB:0]                     div_shift;
    logic [CB:0]                     div_diff;
    logic                            div_ge;
    logic [CB-1:0]                   div_rem_next;

    always_comb
    begin
        // Take the count from the last write or a clear if they overtook the read
        if (clr_last_reg)
        begin
            cur_count = '0;
        end
        else if (wr_valid_reg && (wr_addr_reg == s1_addr_reg))
        begin
            cur_count = wr_data_reg;
        end
        else if (rd_vld_reg)
        begin
            cur_count = rdata_reg;
        end
        else
        begin
            cur_count = '0;
        end
    end

    assign inc_ok    = (cur_count != {CB{1'b1}});
    assign inc_count = cur_count + CB'(1);
    assign at_peak   = (cur_count == peak_reg);

    assign s1_pixel  = (s1_kind_reg == hpn_pkg::KIND_PIXEL);
    assign s1_read   = (s1_kind_reg == hpn_pkg::KIND_READ);
    assign s1_clear  = (s1_kind_reg == hpn_pkg::KIND_CLEAR);

    assign div_busy  = (div_cnt_reg != '0);
    assign res_free  = !div_busy && !out_valid_reg;
    assign s1_go     = s1_valid_reg && (!s1_read || res_free);
    assign in_ready  = !s1_valid_reg || s1_go;
    assign in_acc    = in_valid && in_ready;
    assign rd_addr   = (kind == hpn_pkg::KIND_READ) ? bin : pixel;
    assign mem_we    = s1_go && s1_pixel && inc_ok;

    // One restoring step: the remainder stays below the peak
    assign div_shift    = {div_rem_reg, 1'b0};
    assign div_diff     = div_shift - {1'b0, div_peak_reg};
    assign div_ge       = (div_shift >= {1'b0, div_peak_reg});
    assign div_rem_next = div_ge ? div_diff[CB-1:0] : div_shift[CB-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bin_mem[s1_addr_reg] <= inc_count;
        end
        if (in_acc)
        begin
            rdata_reg <= bin_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_vld_reg   <= '0;
            rd_vld_reg    <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s1_kind_reg   <= hpn_pkg::KIND_PIXEL;
            wr_valid_reg  <= 1'b0;
            clr_last_reg  <= 1'b0;
            peak_reg      <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                rd_vld_reg   <= bin_vld_reg[rd_addr];
                s1_valid_reg <= 1'b1;
                s1_kind_reg  <= hpn_pkg::kind_t'(kind);
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_go)
            begin
                wr_valid_reg <= mem_we;
                clr_last_reg <= s1_clear;
                if (s1_clear)
                begin
                    bin_vld_reg <= '0;
                    peak_reg    <= '0;
                end
                else if (mem_we)
                begin
                    bin_vld_reg[s1_addr_reg] <= 1'b1;
                    if (inc_count > peak_reg)
                    begin
                        peak_reg <= inc_count;
                    end
                end
            end

            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (s1_go && s1_read)
            begin
                if (peak_reg == '0)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    div_cnt_reg <= SB'(hpn_pkg::DIV_STEPS);
                end
            end
            else if (div_busy)
            begin
                div_cnt_reg <= div_cnt_reg - SB'(1);
                if (div_cnt_reg == SB'(1))
                begin
                    out_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            wr_addr_reg <= s1_addr_reg;
            wr_data_reg <= inc_count;
        end
        if (in_acc)
        begin
            s1_addr_reg <= rd_addr;
        end

        if (s1_go && s1_read)
        begin
            cnt_out_reg  <= cur_count[OB-1:0];
            div_peak_reg <= peak_reg;
            empty_reg    <= (peak_reg == '0);
            // Count never exceeds the peak: integer bit is set only at the peak
            quo_reg      <= {{(HB-1){1'b0}}, (peak_reg != '0) && at_peak};
            div_rem_reg  <= at_peak ? '0 : cur_count;
        end
        else if (div_busy)
        begin
            quo_reg     <= {quo_reg[HB-2:0], div_ge};
            div_rem_reg <= div_rem_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign bin_count  = cnt_out_reg;
    assign bar_height = quo_reg;
    assign empty_flag = empty_reg;

    a_div_excl : assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> !out_valid_reg)
        else $error("divider running while a result is held");

    a_height_max : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (quo_reg <= HB'(1 << (HB - 1))))
        else $error("bar height above full scale");

    a_empty_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && empty_reg) |-> (quo_reg == '0) && (cnt_out_reg == '0))
        else $error("empty histogram gave nonzero result");

    a_peak_cover : assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid_reg |-> (peak_reg >= wr_data_reg))
        else $error("peak below a written bin count");

endmodule

/* bench/tb_histogram_peak_normalize_core.sv */
// Self-checking bench for histogram_peak_normalize_core: random valid/ready traffic
// on both channels, and each read reply is checked against an in-bench histogram.
// Depends on hpn_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_histogram_peak_normalize_core;

    localparam logic [hpn_pkg::KIND_BITS-1:0]  KIND_UNUSED = 2'd3;
    localparam logic [hpn_pkg::COUNT_BITS-1:0] COUNT_MAX   = '1;
    localparam int HOT_BINS     = 6;
    localparam int PHASE_ITEMS  = 440;
    localparam int SETTLE       = 30;
    localparam int STALL_LIMIT  = 4000;
    localparam int PRINT_CAP    = 30;
    localparam int QUEUE_DEPTH  = 32;

    typedef struct packed {
        logic [hpn_pkg::KIND_BITS-1:0] kind;
        logic [hpn_pkg::BIN_BITS-1:0]  pixel;
        logic [hpn_pkg::BIN_BITS-1:0]  bin;
    } hist_req_t;

    typedef struct {
        logic [hpn_pkg::OUT_COUNT_BITS-1:0] count;
        logic [hpn_pkg::HEIGHT_BITS-1:0]    height;
        logic                               empty;
    } bar_read_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                               in_valid  = 1'b0;
    logic                               in_ready;
    logic [hpn_pkg::KIND_BITS-1:0]      kind      = '0;
    logic [hpn_pkg::BIN_BITS-1:0]       pixel     = '0;
    logic [hpn_pkg::BIN_BITS-1:0]       bin       = '0;
    logic                               out_valid;
    logic                               out_ready = 1'b0;
    logic [hpn_pkg::OUT_COUNT_BITS-1:0] bin_count;
    logic [hpn_pkg::HEIGHT_BITS-1:0]    bar_height;
    logic                               empty_flag;

    hist_req_t pending_reqs[$];
    bar_read_t due_reads[$];

    logic [hpn_pkg::COUNT_BITS-1:0] hist_bins [hpn_pkg::NUM_BINS] = '{default: '0};
    logic [hpn_pkg::COUNT_BITS-1:0] hist_peak = '0;

    int in_idle_pct  = 12;
    int out_idle_pct = 76;
    int mismatch_count = 0;
    int stall_cycles   = 0;

    histogram_peak_normalize_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .pixel      (pixel),
        .bin        (bin),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .bin_count  (bin_count),
        .bar_height (bar_height),
        .empty_flag (empty_flag)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Advance the histogram by one accepted request; a read queues its reply.
    task automatic update_histogram(input logic [hpn_pkg::KIND_BITS-1:0] k,
                                    input logic [hpn_pkg::BIN_BITS-1:0] p,
                                    input logic [hpn_pkg::BIN_BITS-1:0] b);
        logic [31:0] scaled;
        logic [31:0] quot;
        bar_read_t   reply;
        case (k)
            hpn_pkg::KIND_PIXEL:
            begin
                if (hist_bins[p] != COUNT_MAX)
                begin
                    hist_bins[p] = hist_bins[p] + hpn_pkg::COUNT_BITS'(1);
                    if (hist_bins[p] > hist_peak)
                        hist_peak = hist_bins[p];
                end
            end
            hpn_pkg::KIND_CLEAR:
            begin
                foreach (hist_bins[i])
                    hist_bins[i] = '0;
                hist_peak = '0;
            end
            hpn_pkg::KIND_READ:
            begin
                reply.count  = hist_bins[b][hpn_pkg::OUT_COUNT_BITS-1:0];
                reply.height = '0;
                reply.empty  = 1'b1;
                if (hist_peak != '0)
                begin
                    scaled       = 32'(hist_bins[b]) << 8;
                    quot         = scaled / 32'(hist_peak);
                    reply.height = quot[hpn_pkg::HEIGHT_BITS-1:0];
                    reply.empty  = 1'b0;
                end
                due_reads.push_back(reply);
            end
            default: ;
        endcase
    endtask

    // Sender: hold a request until accepted, then load the next or idle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            kind     <= '0;
            pixel    <= '0;
            bin      <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                update_histogram(kind, pixel, bin);
            if (!in_valid || in_ready)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= in_idle_pct)
                begin
                    hist_req_t r;
                    r = pending_reqs.pop_front();
                    in_valid <= 1'b1;
                    kind     <= r.kind;
                    pixel    <= r.pixel;
                    bin      <= r.bin;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver backpressure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= out_idle_pct);
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            mismatch_count++;
            if (mismatch_count <= PRINT_CAP)
                $display("%0t: %s mismatch, expected %0d actual %0d",
                         $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (due_reads.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= PRINT_CAP)
                    $display("%0t: unexpected reply, expected none, actual %0d %0d %0d",
                             $time, bin_count, bar_height, empty_flag);
            end
            else
            begin
                bar_read_t want;
                want = due_reads.pop_front();
                check_field("bin_count", want.count, bin_count);
                check_field("bar_height", want.height, bar_height);
                check_field("empty_flag", want.empty, empty_flag);
            end
        end
    end

    // Watchdog: end the run when neither channel moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic push_req(input logic [hpn_pkg::KIND_BITS-1:0] k, input int p,
                            input int b);
        hist_req_t r;
        while (pending_reqs.size() >= QUEUE_DEPTH)
            @(negedge clk);
        r.kind  = k;
        r.pixel = p[hpn_pkg::BIN_BITS-1:0];
        r.bin   = b[hpn_pkg::BIN_BITS-1:0];
        pending_reqs.push_back(r);
    endtask

    // Mostly pixels aimed at a few hot bins so peaks and heights move around.
    task automatic push_random_req();
        int roll;
        int p;
        int b;
        roll = $urandom_range(99);
        p    = $urandom_range(255);
        b    = $urandom_range(255);
        if (roll < 70)
        begin
            if ($urandom_range(1))
                p = $urandom_range(HOT_BINS - 1);
            push_req(hpn_pkg::KIND_PIXEL, p, b);
        end
        else if (roll < 95)
        begin
            if ($urandom_range(1))
                b = $urandom_range(HOT_BINS - 1);
            push_req(hpn_pkg::KIND_READ, p, b);
        end
        else if (roll < 97)
            push_req(hpn_pkg::KIND_CLEAR, p, b);
        else
            push_req(KIND_UNUSED, p, b);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || in_valid || due_reads.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty reads, edge bins, full-scale height, clear, ignored kind.
        push_req(hpn_pkg::KIND_READ, 8'hff, 0);
        push_req(hpn_pkg::KIND_READ, 0, 255);
        push_req(KIND_UNUSED, 8'hff, 8'hff);
        push_req(hpn_pkg::KIND_PIXEL, 0, 8'hff);
        push_req(hpn_pkg::KIND_PIXEL, 255, 0);
        push_req(hpn_pkg::KIND_PIXEL, 255, 0);
        push_req(hpn_pkg::KIND_READ, 0, 0);
        push_req(hpn_pkg::KIND_READ, 0, 255);
        push_req(hpn_pkg::KIND_READ, 0, 128);
        push_req(hpn_pkg::KIND_CLEAR, 0, 0);
        push_req(hpn_pkg::KIND_READ, 0, 255);
        push_req(hpn_pkg::KIND_PIXEL, 128, 0);
        push_req(hpn_pkg::KIND_PIXEL, 128, 0);
        push_req(hpn_pkg::KIND_PIXEL, 128, 0);
        push_req(hpn_pkg::KIND_PIXEL, 1, 0);
        push_req(hpn_pkg::KIND_READ, 0, 128);
        push_req(hpn_pkg::KIND_READ, 0, 1);
        push_req(KIND_UNUSED, 1, 1);
        push_req(hpn_pkg::KIND_READ, 0, 1);
        push_req(hpn_pkg::KIND_CLEAR, 255, 255);
        push_req(hpn_pkg::KIND_READ, 255, 0);

        for (int n = 0; n < PHASE_ITEMS; n++)
            push_random_req();
        wait_drained();

        in_idle_pct  = 76;
        out_idle_pct = 12;
        for (int n = 0; n < PHASE_ITEMS; n++)
            push_random_req();
        wait_drained();

        in_idle_pct  = 0;
        out_idle_pct = 0;
        for (int n = 0; n < PHASE_ITEMS; n++)
            push_random_req();

        // Grow two bins at full rate, then read them back against each other.
        push_req(hpn_pkg::KIND_CLEAR, 0, 0);
        for (int n = 0; n < 20; n++)
            push_req(hpn_pkg::KIND_PIXEL, 7, $urandom_range(255));
        for (int n = 0; n < 7; n++)
            push_req(hpn_pkg::KIND_PIXEL, 9, $urandom_range(255));
        push_req(hpn_pkg::KIND_READ, 0, 9);
        push_req(hpn_pkg::KIND_READ, 0, 7);
        push_req(hpn_pkg::KIND_PIXEL, 7, 0);
        push_req(hpn_pkg::KIND_READ, 0, 7);
        push_req(hpn_pkg::KIND_READ, 0, 10);
        push_req(hpn_pkg::KIND_CLEAR, 0, 0);
        push_req(hpn_pkg::KIND_READ, 0, 7);
        wait_drained();

        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
